/* src/trrc_pkg.sv */
// Shared types and constants for the tandem repeat run counter.
`timescale 1ns / 1ps
package trrc_pkg;

    localparam int NUM_PATTERNS    = 8;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int COUNT_WIDTH     = 16;

    localparam logic [2:0] OTHER_SYMBOL = 3'd4;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [2:0] t_base;
    // Tap 0 is the current base, tap k the base k positions back
    typedef t_base [MAX_PATTERN_LEN-1:0] t_window;

    // Configuration register indexes
    typedef enum logic [3:0] {
        CFG_BASES_LOW  = 4'd0,
        CFG_BASES_HIGH = 4'd1,
        CFG_LENGTHS    = 4'd2,
        CFG_IN_USE     = 4'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] base;
        logic       end_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  pattern_index;
        logic [15:0] longest_run;
        logic        last_of_run;
    } t_out_item;

    // Per-lane control from the top level
    typedef struct packed {
        logic step;   // an input transfer happens this cycle
        logic clear;  // it ends the sequence: wipe running state
    } t_lane_ctl;

endpackage

/* src/trrc_lane.sv */
// One pattern lane: match detect, run history shift line and best-run register.
`timescale 1ns / 1ps
module trrc_lane
    import trrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_lane_ctl   i_ctl,
    input  t_window     i_window,
    input  logic [15:0] i_pat_bases,
    input  logic [3:0]  i_pat_len,
    output t_count      o_best_next
);

    t_count r_hist [MAX_PATTERN_LEN];
    t_count r_best;

    logic   hit;
    t_count prev;
    t_count n_run;

    // Pattern ends at the current base: base j sits len-1-j taps back
    always_comb begin
        logic [2:0] tap;
        t_base      b;
        hit = (i_pat_len != 4'd0) && (i_pat_len <= 4'(MAX_PATTERN_LEN));
        tap = '0;
        b   = '0;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
            if (4'(j) < i_pat_len) begin
                tap = 3'(i_pat_len - 4'd1 - 4'(j));
                b   = i_window[tap];
                if (b[2] || (b[1:0] != i_pat_bases[2*j +: 2])) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // Run ending here extends the run that ended one pattern length ago
    always_comb begin
        prev = r_hist[3'(i_pat_len - 4'd1)];
        if (!hit) begin
            n_run = '0;
        end else if (prev == COUNT_MAX) begin
            n_run = COUNT_MAX;
        end else begin
            n_run = prev + t_count'(1);
        end
        o_best_next = (n_run > r_best) ? n_run : r_best;
    end

    // History shift line and best run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                r_hist[k] <= '0;
            end
            r_best <= '0;
        end else if (i_ctl.step) begin
            for (int k = MAX_PATTERN_LEN - 1; k > 0; k--) begin
                r_hist[k] <= r_hist[k-1];
            end
            r_hist[0] <= n_run;
            r_best    <= o_best_next;
        end
    end

    // A base that completes no copy records a zero run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !i_ctl.clear && !hit) |=> (r_hist[0] == '0))
        else $error("trrc_lane: run recorded without a match");

endmodule

/* src/tandem_repeat_run_counter_unit.sv */
// Top level of the tandem repeat run counter: config, base window, lanes, result drain.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//  cfg     | input     | i_cfg_wr_en               | i_cfg_index, i_cfg_data
//
// One base is taken per cycle unless stalled; all lanes update in the transfer cycle.
// An end-of-sequence base loads the result bank; results leave one per cycle
// when not stalled, one per pattern in use, while bases of the next sequence flow on.
// A further end-of-sequence base stalls until the bank has drained.
// Synchronous active-low reset clears config to defaults and all running state.
`timescale 1ns / 1ps
module tandem_repeat_run_counter_unit
    import trrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_bases_low;
    logic [63:0] r_bases_high;
    logic [31:0] r_lengths;
    logic [3:0]  r_in_use;

    t_base       r_recent [MAX_PATTERN_LEN-1];
    t_window     window;
    t_lane_ctl   lane_ctl;
    t_count      best_next [NUM_PATTERNS];
    logic [127:0] all_bases;

    t_count      r_bank [NUM_PATTERNS];
    logic        r_busy;
    logic [2:0]  r_idx;
    logic [3:0]  r_cnt;
    logic [3:0]  n_use;
    logic        in_xfer;
    logic        out_xfer;
    logic        out_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases_low  <= '0;
            r_bases_high <= '0;
            r_lengths    <= '0;
            r_in_use     <= 4'd8;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_BASES_LOW:  r_bases_low  <= i_cfg_data;
                CFG_BASES_HIGH: r_bases_high <= i_cfg_data;
                CFG_LENGTHS:    r_lengths    <= i_cfg_data[31:0];
                CFG_IN_USE:     r_in_use     <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Input handshake: a sequence end waits until the result bank is free
    assign o_in_stall = r_busy && i_in_item.end_of_sequence;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign lane_ctl.step  = in_xfer;
    assign lane_ctl.clear = i_in_item.end_of_sequence;

    // Base window: current base then the previous ones, newest first
    always_comb begin
        window[0] = i_in_item.base;
        for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
            window[k] = r_recent[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_xfer && i_in_item.end_of_sequence)) begin
            for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) begin
                r_recent[k] <= OTHER_SYMBOL;
            end
        end else if (in_xfer) begin
            for (int k = MAX_PATTERN_LEN - 2; k > 0; k--) begin
                r_recent[k] <= r_recent[k-1];
            end
            r_recent[0] <= i_in_item.base;
        end
    end

    // Pattern lanes
    assign all_bases = {r_bases_high, r_bases_low};

    for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_lane
        trrc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl),
            .i_window    (window),
            .i_pat_bases (all_bases[16*p +: 16]),
            .i_pat_len   (r_lengths[4*p +: 4]),
            .o_best_next (best_next[p])
        );
    end

    // Number of results for a sequence end, limited to the lane count
    assign n_use = (r_in_use > 4'(NUM_PATTERNS)) ? 4'(NUM_PATTERNS) : r_in_use;

    // Result bank: snapshot on sequence end, then drain one per transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_item.end_of_sequence) begin
            for (int p = 0; p < NUM_PATTERNS; p++) begin
                r_bank[p] <= best_next[p];
            end
        end
    end

    assign o_out_valid = r_busy;
    assign out_xfer    = r_busy && !i_out_stall;
    assign out_last    = ({1'b0, r_idx} + 4'd1) == r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (in_xfer && i_in_item.end_of_sequence) begin
            r_busy <= (n_use != 4'd0);
            r_idx  <= '0;
            r_cnt  <= n_use;
        end else if (out_xfer) begin
            if (out_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    assign o_out_item.pattern_index = r_idx;
    assign o_out_item.longest_run   = r_bank[r_idx];
    assign o_out_item.last_of_run   = out_last;

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("trrc: result index beyond patterns in use");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_item.end_of_sequence && (n_use != 4'd0))
            |=> (o_out_valid && (r_idx == 3'd0)))
        else $error("trrc: sequence end did not start the result drain");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && out_last) |=> !o_out_valid)
        else $error("trrc: results continue past the final pattern");

endmodule
